### rtl/amc_pkg.sv
// Package for the adaptive measurement cadence block: word types, codes and ladder table.
`timescale 1ns / 1ps
`default_nettype none
package amc_pkg;

  typedef struct packed {
    logic [13:0] glucose_tenths;
    logic        glucose_ok;
    logic [31:0] now_sec;
    logic [8:0]  heart_rate;
    logic        heart_rate_ok;
    logic [6:0]  oxygen_pct;
    logic        oxygen_ok;
    logic        ext_power;
    logic        charge_known;
    logic [6:0]  charge_pct;
  } amc_in_t;

  typedef struct packed {
    logic [11:0] interval_sec;
    logic [2:0]  ladder_step;
    logic [2:0]  decision;
  } amc_out_t;

  typedef enum logic [2:0] {
    DEC_FIXED    = 3'd0,
    DEC_NO_GLU   = 3'd1,
    DEC_CRITICAL = 3'd2,
    DEC_ABNORMAL = 3'd3,
    DEC_MOVING   = 3'd4,
    DEC_VITALS   = 3'd5,
    DEC_STABLE   = 3'd6
  } amc_dec_t;

  typedef enum logic [2:0] {
    REG_FIXED_INTERVAL = 3'd0,
    REG_CRIT_LOW       = 3'd1,
    REG_CRIT_HIGH      = 3'd2,
    REG_ABN_LOW        = 3'd3,
    REG_ABN_HIGH       = 3'd4,
    REG_BATT_LOW       = 3'd5,
    REG_BATT_CRIT      = 3'd6
  } amc_reg_t;

  localparam int          RELAX_AFTER      = 2;
  localparam logic [2:0]  LADDER_SLOWEST   = 3'd4;
  localparam logic [2:0]  LADDER_LOW_FLOOR = 3'd2;
  localparam logic [2:0]  LADDER_RESET     = 3'd1;
  localparam logic [11:0] FIXED_MIN        = 12'd60;
  localparam logic [11:0] FIXED_MAX        = 12'd3600;
  localparam logic [6:0]  OXY_LOW          = 7'd92;
  localparam logic [8:0]  HR_HIGH          = 9'd100;
  localparam logic [8:0]  HR_LOW           = 9'd45;
  localparam logic [31:0] DT_MIN           = 32'd6;

  function automatic logic [11:0] ladder_value(input logic [2:0] idx);
    logic [11:0] v;
    case (idx)
      3'd0: v = 12'd300;
      3'd1: v = 12'd600;
      3'd2: v = 12'd900;
      3'd3: v = 12'd1200;
      default: v = 12'd1800;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/adaptive_measurement_cadence.sv
// Adaptive measurement cadence: picks the next measurement interval from one report word.
// Pipeline: input register then result register; a word moves into the result register
// when the output is not stalled. Throughput: one word per cycle while out_stall is low;
// ladder state updates as the result loads, so the next word sees it without bubbles.
// Reset (rst_n low, synchronous): registers back to defaults, ladder step 1 (600 s),
// stable count and prior reading cleared, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_measurement_cadence
  import amc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire amc_in_t     in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output amc_out_t         out_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  localparam logic [1:0] RelaxAfterC = 2'(RELAX_AFTER);

  logic [11:0] fixed_interval_r;
  logic [13:0] crit_low_r, crit_high_r, abn_low_r, abn_high_r;
  logic [6:0]  batt_low_r, batt_crit_r;

  logic [2:0]  ladder_r, ladder_nxt;
  logic [1:0]  stable_r, stable_nxt;
  logic        prior_ok_r, prior_ok_nxt;
  logic [13:0] prior_g_r, prior_g_nxt;
  logic [31:0] prior_t_r, prior_t_nxt;

  amc_in_t     s1_word_r;
  logic        s1_valid_r;
  amc_out_t    out_word_r, res_nxt;
  logic        out_valid_r;

  logic        adv, s1_fire;

  logic [13:0] d;
  logic [31:0] dt;
  logic [33:0] lhs, dt1, dt2, dt3;
  logic        have_rate, vit, crit, abn, moving;
  logic [1:0]  sc_inc;
  logic [11:0] fixed_clamped;
  logic [2:0]  dec;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && adv;
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_interval_r <= 12'd0;
      crit_low_r       <= 14'd540;
      crit_high_r      <= 14'd2500;
      abn_low_r        <= 14'd700;
      abn_high_r       <= 14'd1800;
      batt_low_r       <= 7'd20;
      batt_crit_r      <= 7'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIXED_INTERVAL: fixed_interval_r <= cfg_data[11:0];
        REG_CRIT_LOW:       crit_low_r       <= cfg_data;
        REG_CRIT_HIGH:      crit_high_r      <= cfg_data;
        REG_ABN_LOW:        abn_low_r        <= cfg_data;
        REG_ABN_HIGH:       abn_high_r       <= cfg_data;
        REG_BATT_LOW:       batt_low_r       <= cfg_data[6:0];
        REG_BATT_CRIT:      batt_crit_r      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // decision logic
  always_comb begin
    ladder_nxt   = ladder_r;
    stable_nxt   = stable_r;
    prior_ok_nxt = prior_ok_r;
    prior_g_nxt  = prior_g_r;
    prior_t_nxt  = prior_t_r;
    dec          = DEC_FIXED;

    d  = (s1_word_r.glucose_tenths >= prior_g_r) ? s1_word_r.glucose_tenths - prior_g_r
                                                  : prior_g_r - s1_word_r.glucose_tenths;
    dt = s1_word_r.now_sec - prior_t_r;
    have_rate = prior_ok_r && (s1_word_r.now_sec > prior_t_r) && (dt > DT_MIN);
    lhs = 34'({d, 2'b00}) + 34'({d, 1'b0});
    dt1 = 34'(dt);
    dt2 = {1'b0, dt, 1'b0};
    dt3 = dt1 + dt2;

    crit = (s1_word_r.glucose_tenths < crit_low_r) || (s1_word_r.glucose_tenths > crit_high_r)
           || (have_rate && lhs > dt3);
    abn  = (s1_word_r.glucose_tenths < abn_low_r) || (s1_word_r.glucose_tenths > abn_high_r)
           || (have_rate && lhs > dt2);
    moving = have_rate && lhs > dt1;
    vit = (s1_word_r.oxygen_ok && s1_word_r.oxygen_pct != 7'd0 &&
           s1_word_r.oxygen_pct < OXY_LOW) ||
          (s1_word_r.heart_rate_ok && s1_word_r.heart_rate != 9'd0 &&
           (s1_word_r.heart_rate > HR_HIGH || s1_word_r.heart_rate < HR_LOW));
    sc_inc = stable_r + 2'd1;

    fixed_clamped = fixed_interval_r;
    if (fixed_interval_r < FIXED_MIN) fixed_clamped = FIXED_MIN;
    if (fixed_interval_r > FIXED_MAX) fixed_clamped = FIXED_MAX;

    if (fixed_interval_r != 12'd0) begin
      res_nxt = '{interval_sec: fixed_clamped, ladder_step: ladder_r, decision: DEC_FIXED};
    end else begin
      if (!s1_word_r.glucose_ok) begin
        stable_nxt = 2'd0;
        dec        = DEC_NO_GLU;
      end else begin
        prior_ok_nxt = 1'b1;
        prior_g_nxt  = s1_word_r.glucose_tenths;
        prior_t_nxt  = s1_word_r.now_sec;
        if (crit) begin
          ladder_nxt = 3'd0;
          stable_nxt = 2'd0;
          dec        = DEC_CRITICAL;
        end else if (abn || vit && !moving) begin
          if (ladder_r != 3'd0) ladder_nxt = ladder_r - 3'd1;
          stable_nxt = 2'd0;
          dec        = abn ? DEC_ABNORMAL : DEC_VITALS;
        end else if (moving) begin
          stable_nxt = 2'd0;
          dec        = DEC_MOVING;
        end else begin
          stable_nxt = sc_inc;
          if (sc_inc >= RelaxAfterC) begin
            if (ladder_r < LADDER_SLOWEST) ladder_nxt = ladder_r + 3'd1;
            stable_nxt = 2'd0;
          end
          dec = DEC_STABLE;
        end
      end
      // battery floor
      if (!s1_word_r.ext_power && s1_word_r.charge_known) begin
        if (s1_word_r.charge_pct < batt_crit_r) begin
          ladder_nxt = LADDER_SLOWEST;
        end else if (s1_word_r.charge_pct < batt_low_r && ladder_nxt < LADDER_LOW_FLOOR) begin
          ladder_nxt = LADDER_LOW_FLOOR;
        end
      end
      res_nxt = '{interval_sec: ladder_value(ladder_nxt), ladder_step: ladder_nxt,
                  decision: dec};
    end
  end

  // pipeline control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ladder_r    <= LADDER_RESET;
      stable_r    <= 2'd0;
      prior_ok_r  <= 1'b0;
      prior_g_r   <= 14'd0;
      prior_t_r   <= 32'd0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
      if (s1_fire) begin
        ladder_r   <= ladder_nxt;
        stable_r   <= stable_nxt;
        prior_ok_r <= prior_ok_nxt;
        prior_g_r  <= prior_g_nxt;
        prior_t_r  <= prior_t_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_word_r <= in_word;
    if (s1_fire) out_word_r <= res_nxt;
  end

endmodule
`default_nettype wire
